// ===== hdl/gbi_pkg.sv =====
`default_nettype none

package gbi_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int QUEUE_DEPTH       = 2;
   localparam int CSR_ADDR_W        = 4;

   // Register indexes (byte address / 4)
   localparam logic [1:0] REG_BODY_MASS    = 2'd0;
   localparam logic [1:0] REG_GRAVITY_GAIN = 2'd1;
   localparam logic [1:0] REG_SPEED_LIMIT  = 2'd2;

   localparam logic [7:0]  BODY_MASS_RESET    = 8'd2;
   localparam logic [7:0]  GRAVITY_GAIN_RESET = 8'd2;
   localparam logic [15:0] SPEED_LIMIT_RESET  = 16'd1000;

   typedef enum logic [1:0] {
      ACT_PLACE   = 2'd0,
      ACT_PULL    = 2'd1,
      ACT_ADVANCE = 2'd2,
      ACT_NOP     = 2'd3
   } action_type;

   typedef struct packed {
      action_type         action;
      logic signed [31:0] other_x;
      logic signed [31:0] other_y;
      logic [7:0]         other_mass;
      logic signed [31:0] place_vel_x;
      logic signed [31:0] place_vel_y;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] accel_x;
      logic signed [31:0] accel_y;
   } body_type;

   typedef struct packed {
      logic [7:0]  body_mass;
      logic [7:0]  gravity_gain;
      logic [15:0] speed_limit;
   } cfg_type;

   typedef struct packed {
      logic [31:0] num;
      logic [6:0]  shift;
      logic [63:0] den;
      logic [32:0] cap;
   } div_cmd_type;

   typedef struct packed {
      logic [1:0] count;
   } fq_status_type;

endpackage

`default_nettype wire

// ===== hdl/gbi_req_if.sv =====
`default_nettype none

interface gbi_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic signed [31:0] other_x;
   logic signed [31:0] other_y;
   logic [7:0]         other_mass;
   logic signed [31:0] place_vel_x;
   logic signed [31:0] place_vel_y;

   modport source (output valid, action, other_x, other_y, other_mass, place_vel_x,
                   place_vel_y, input ready);
   modport sink (input valid, action, other_x, other_y, other_mass, place_vel_x,
                 place_vel_y, output ready);
endinterface

`default_nettype wire

// ===== hdl/gbi_rsp_if.sv =====
`default_nettype none

interface gbi_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] vel_x;
   logic signed [31:0] vel_y;
   logic signed [31:0] accel_x;
   logic signed [31:0] accel_y;

   modport source (output valid, pos_x, pos_y, vel_x, vel_y, accel_x, accel_y,
                   input ready);
   modport sink (input valid, pos_x, pos_y, vel_x, vel_y, accel_x, accel_y,
                 output ready);
endinterface

`default_nettype wire

// ===== hdl/gbi_front.sv =====
`default_nettype none

module gbi_front import gbi_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   gbi_req_if.sink       req,
   output logic          head_valid,
   input  logic          head_pop,
   output req_item_type  head_item,
   output fq_status_type status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   req_item_type     slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [1:0]       count_ff;
   req_item_type     item_in;
   logic             push;
   logic             pop;

   // classify the raw action code
   always_comb begin
      item_in.action      = action_type'(req.action);
      item_in.other_x     = req.other_x;
      item_in.other_y     = req.other_y;
      item_in.other_mass  = req.other_mass;
      item_in.place_vel_x = req.place_vel_x;
      item_in.place_vel_y = req.place_vel_y;
   end

   assign req.ready    = (count_ff != 2'(QUEUE_DEPTH));
   assign push         = req.valid && req.ready;
   assign head_valid   = (count_ff != 2'd0);
   assign pop          = head_pop && head_valid;
   assign head_item    = slot_ff[rd_ptr_ff];
   assign status.count = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/gbi_div.sv =====
`default_nettype none

module gbi_div import gbi_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  div_cmd_type cmd,
   output logic        done,
   output logic [32:0] quot
);

   div_cmd_type cmd_ff;
   logic        run_ff;
   logic        done_ff;
   logic [6:0]  idx_ff;
   logic [63:0] rem_ff;
   logic [32:0] qt_ff;
   logic        sat_ff;
   logic [32:0] quot_ff;

   logic        bit_in;
   logic [6:0]  sel;
   logic [64:0] rem_sh;
   logic        ge;
   logic [64:0] rem_sub;
   logic [33:0] qt_sh;
   logic        sat_in;

   always_comb begin
      sel    = idx_ff - cmd_ff.shift;
      bit_in = (idx_ff >= cmd_ff.shift) ? cmd_ff.num[sel[4:0]] : 1'b0;
      rem_sh = {rem_ff, bit_in};
      ge     = (rem_sh >= {1'b0, cmd_ff.den});
      rem_sub = ge ? (rem_sh - {1'b0, cmd_ff.den}) : rem_sh;
      qt_sh  = {qt_ff, ge};
      sat_in = sat_ff || (qt_sh > {1'b0, cmd_ff.cap});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && idx_ff == 7'd0) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (start) begin
         cmd_ff <= cmd;
         idx_ff <= 7'd31 + cmd.shift;
         rem_ff <= '0;
         qt_ff  <= '0;
         sat_ff <= 1'b0;
      end else if (run_ff) begin
         idx_ff <= idx_ff - 7'd1;
         rem_ff <= rem_sub[63:0];
         qt_ff  <= qt_sh[32:0];
         sat_ff <= sat_in;
         if (idx_ff == 7'd0) begin
            quot_ff <= sat_in ? cmd_ff.cap : qt_sh[32:0];
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

// ===== hdl/gbi_back.sv =====
`default_nettype none

module gbi_back import gbi_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         head_valid,
   input  req_item_type head_item,
   output logic         head_pop,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output body_type     rsp_body
);

   localparam int         SHIFT2 = 2 * FRAC_BITS;
   localparam logic [6:0] E3     = 7'(3 * FRAC_BITS);

   typedef enum logic [4:0] {
      S_IDLE, S_PULL_MAG, S_PULL_SQX, S_PULL_SQY, S_PULL_SQR, S_PULL_CMP,
      S_PULL_QX, S_PULL_QY, S_PULL_QSUM, S_PULL_QCHK, S_PULL_SQRT,
      S_PULL_MAG_GO, S_PULL_MAG_WT, S_PULL_CX_GO, S_PULL_CX_WT,
      S_PULL_CY_GO, S_PULL_CY_WT, S_PULL_AX, S_PULL_AY, S_PULL_ACCY,
      S_ADV_MAG, S_ADV_SQX, S_ADV_SQY, S_ADV_SQL, S_ADV_CMP, S_ADV_POS, S_DONE
   } state_type;

   function automatic logic signed [31:0] sat_acc(input logic signed [31:0] acc,
                                                  input logic [34:0] part,
                                                  input logic neg);
      logic signed [36:0] sp;
      logic signed [36:0] sum;
      sp  = $signed({2'b00, part});
      sum = 37'(acc) + (neg ? -sp : sp);
      if (sum > 37'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (sum < -37'sd2147483648) begin
         return 32'sh80000000;
      end
      return sum[31:0];
   endfunction

   function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
      if (v > 33'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -33'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   state_type          state_ff;
   body_type           body_ff;
   logic [7:0]         mass_ff;
   logic signed [32:0] dx_ff;
   logic signed [32:0] dy_ff;
   logic [32:0]        ux_ff;
   logic [32:0]        uy_ff;
   logic               s_ff;
   logic [31:0]        vx_ff;
   logic [31:0]        vy_ff;
   logic [65:0]        prod_ff;
   logic [66:0]        sum_ff;
   logic [63:0]        q_ff;
   logic [63:0]        sq_res_ff;
   logic [63:0]        sq_rem_ff;
   logic [63:0]        sq_bit_ff;
   logic [4:0]         sq_cnt_ff;
   logic [32:0]        mag_ff;
   logic [32:0]        cx_ff;
   logic [32:0]        cy_ff;
   logic               rsp_valid_ff;
   body_type           rsp_ff;

   logic [32:0]        mul_a;
   logic [32:0]        mul_b;
   logic [66:0]        col_lim;
   logic [80:0]        spd_lim;
   logic [63:0]        sq_try;
   logic               div_start;
   div_cmd_type        div_cmd;
   logic               div_done;
   logic [32:0]        div_quot;
   logic               out_free;

   gbi_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .cmd   (div_cmd),
      .done  (div_done),
      .quot  (div_quot)
   );

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_PULL_SQX, S_ADV_SQX: begin mul_a = ux_ff; mul_b = ux_ff; end
         S_PULL_SQY, S_ADV_SQY: begin mul_a = uy_ff; mul_b = uy_ff; end
         S_PULL_SQR: begin
            mul_a = {24'd0, mass_ff, 1'b0};
            mul_b = {24'd0, mass_ff, 1'b0};
         end
         S_PULL_QX: begin mul_a = {1'b0, vx_ff}; mul_b = {1'b0, vx_ff}; end
         S_PULL_QY: begin mul_a = {1'b0, vy_ff}; mul_b = {1'b0, vy_ff}; end
         S_PULL_AX: begin mul_a = mag_ff; mul_b = cx_ff; end
         S_PULL_AY: begin mul_a = mag_ff; mul_b = cy_ff; end
         S_ADV_SQL: begin
            mul_a = {17'd0, cfg.speed_limit};
            mul_b = {17'd0, cfg.speed_limit};
         end
         default: ;
      endcase
   end

   always_comb begin
      col_lim   = {1'b0, prod_ff} << SHIFT2;
      spd_lim   = 81'(prod_ff) << SHIFT2;
      sq_try    = sq_res_ff + sq_bit_ff;
      div_start = (state_ff == S_PULL_MAG_GO) || (state_ff == S_PULL_CX_GO) ||
                  (state_ff == S_PULL_CY_GO);
      div_cmd   = '0;
      if (state_ff == S_PULL_MAG_GO) begin
         div_cmd.num   = {16'd0, 16'(cfg.gravity_gain) * 16'(mass_ff)};
         div_cmd.shift = E3 - {5'd0, s_ff, 1'b0};
         div_cmd.den   = q_ff;
         div_cmd.cap   = 33'h1_0000_0000;
      end else if (state_ff == S_PULL_CX_GO) begin
         div_cmd.num   = vx_ff;
         div_cmd.shift = 7'd31;
         div_cmd.den   = {32'd0, sq_res_ff[31:0]};
         div_cmd.cap   = 33'h0_8000_0000;
      end else begin
         div_cmd.num   = vy_ff;
         div_cmd.shift = 7'd31;
         div_cmd.den   = {32'd0, sq_res_ff[31:0]};
         div_cmd.cap   = 33'h0_8000_0000;
      end
      head_pop = (state_ff == S_IDLE) && head_valid;
      out_free = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         body_ff      <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (head_valid) begin
                  unique case (head_item.action)
                     ACT_PLACE: begin
                        body_ff.pos_x <= head_item.other_x;
                        body_ff.pos_y <= head_item.other_y;
                        body_ff.vel_x <= head_item.place_vel_x;
                        body_ff.vel_y <= head_item.place_vel_y;
                        state_ff      <= S_DONE;
                     end
                     ACT_PULL: begin
                        dx_ff    <= 33'(head_item.other_x) - 33'(body_ff.pos_x);
                        dy_ff    <= 33'(head_item.other_y) - 33'(body_ff.pos_y);
                        mass_ff  <= cfg.body_mass;
                        vx_ff    <= {24'd0, head_item.other_mass};
                        state_ff <= S_PULL_MAG;
                     end
                     ACT_ADVANCE: begin
                        dx_ff    <= 33'(body_ff.vel_x) + 33'(body_ff.accel_x);
                        dy_ff    <= 33'(body_ff.vel_y) + 33'(body_ff.accel_y);
                        state_ff <= S_ADV_MAG;
                     end
                     ACT_NOP: state_ff <= S_DONE;
                  endcase
               end
            end
            S_PULL_MAG: begin
               ux_ff    <= dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
               uy_ff    <= dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);
               state_ff <= S_PULL_SQX;
            end
            S_PULL_SQX: state_ff <= S_PULL_SQY;
            S_PULL_SQY: begin
               sum_ff   <= {1'b0, prod_ff};
               state_ff <= S_PULL_SQR;
            end
            S_PULL_SQR: begin
               sum_ff   <= sum_ff + {1'b0, prod_ff};
               // collision radius done: swap mass back to the other body's
               mass_ff  <= vx_ff[7:0];
               state_ff <= S_PULL_CMP;
            end
            S_PULL_CMP: begin
               if (sum_ff < col_lim) begin
                  state_ff <= S_DONE;
               end else begin
                  s_ff <= (|ux_ff[32:31]) || (|uy_ff[32:31]);
                  if ((|ux_ff[32:31]) || (|uy_ff[32:31])) begin
                     vx_ff <= ux_ff[32:1];
                     vy_ff <= uy_ff[32:1];
                  end else begin
                     vx_ff <= ux_ff[31:0];
                     vy_ff <= uy_ff[31:0];
                  end
                  state_ff <= S_PULL_QX;
               end
            end
            S_PULL_QX: state_ff <= S_PULL_QY;
            S_PULL_QY: begin
               q_ff     <= prod_ff[63:0];
               state_ff <= S_PULL_QSUM;
            end
            S_PULL_QSUM: begin
               q_ff     <= q_ff + prod_ff[63:0];
               state_ff <= S_PULL_QCHK;
            end
            S_PULL_QCHK: begin
               if (q_ff == 64'd0) begin
                  state_ff <= S_DONE;
               end else begin
                  sq_rem_ff <= q_ff;
                  sq_res_ff <= '0;
                  sq_bit_ff <= 64'd1 << 62;
                  sq_cnt_ff <= '0;
                  state_ff  <= S_PULL_SQRT;
               end
            end
            S_PULL_SQRT: begin
               // one result bit per cycle
               if (sq_rem_ff >= sq_try) begin
                  sq_rem_ff <= sq_rem_ff - sq_try;
                  sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
               end else begin
                  sq_res_ff <= sq_res_ff >> 1;
               end
               sq_bit_ff <= sq_bit_ff >> 2;
               sq_cnt_ff <= sq_cnt_ff + 5'd1;
               if (sq_cnt_ff == 5'd31) begin
                  state_ff <= S_PULL_MAG_GO;
               end
            end
            S_PULL_MAG_GO: state_ff <= S_PULL_MAG_WT;
            S_PULL_MAG_WT: begin
               if (div_done) begin
                  mag_ff   <= div_quot;
                  state_ff <= S_PULL_CX_GO;
               end
            end
            S_PULL_CX_GO: state_ff <= S_PULL_CX_WT;
            S_PULL_CX_WT: begin
               if (div_done) begin
                  cx_ff    <= div_quot;
                  state_ff <= S_PULL_CY_GO;
               end
            end
            S_PULL_CY_GO: state_ff <= S_PULL_CY_WT;
            S_PULL_CY_WT: begin
               if (div_done) begin
                  cy_ff    <= div_quot;
                  state_ff <= S_PULL_AX;
               end
            end
            S_PULL_AX: state_ff <= S_PULL_AY;
            S_PULL_AY: begin
               body_ff.accel_x <= sat_acc(body_ff.accel_x, prod_ff[65:31], dx_ff[32]);
               state_ff        <= S_PULL_ACCY;
            end
            S_PULL_ACCY: begin
               body_ff.accel_y <= sat_acc(body_ff.accel_y, prod_ff[65:31], dy_ff[32]);
               state_ff        <= S_DONE;
            end
            S_ADV_MAG: begin
               ux_ff    <= dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
               uy_ff    <= dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);
               state_ff <= S_ADV_SQX;
            end
            S_ADV_SQX: state_ff <= S_ADV_SQY;
            S_ADV_SQY: begin
               sum_ff   <= {1'b0, prod_ff};
               state_ff <= S_ADV_SQL;
            end
            S_ADV_SQL: begin
               sum_ff   <= sum_ff + {1'b0, prod_ff};
               state_ff <= S_ADV_CMP;
            end
            S_ADV_CMP: begin
               if (81'(sum_ff) <= spd_lim) begin
                  body_ff.vel_x <= sat33(dx_ff);
                  body_ff.vel_y <= sat33(dy_ff);
               end
               state_ff <= S_ADV_POS;
            end
            S_ADV_POS: begin
               body_ff.pos_x   <= body_ff.pos_x + body_ff.vel_x;
               body_ff.pos_y   <= body_ff.pos_y + body_ff.vel_y;
               body_ff.accel_x <= '0;
               body_ff.accel_y <= '0;
               state_ff        <= S_DONE;
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_ff       <= body_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_body  = rsp_ff;

endmodule

`default_nettype wire

// ===== hdl/gravity_body_integrator.sv =====
`default_nettype none

// One point mass of a 2D gravity simulation in signed Q(32-FRAC_BITS).FRAC_BITS.
// Send items on req: action 0 places the body (position from other_x/y,
// velocity from place_vel_x/y), 1 pulls it toward another body at other_x/y
// with mass other_mass (skipped inside the radius 2*body_mass), 2 advances one
// frame (velocity update gated by speed_limit, position move, accumulator
// clear), 3 changes nothing. Every item returns one rsp item with the full
// state after it. A two-entry queue sits in front of a sequencer that owns the
// state and one shared 33x33 multiplier, so req keeps taking items while a
// pull is still running or a result waits on rsp. The time a pull takes is set
// by the bit-serial square root and the bit-serial divider that runs three
// times (force magnitude, then the two direction cosines, one quotient bit per
// cycle each). Write registers over the APB port only while the block is idle:
// body_mass at 0x0, gravity_gain at 0x4, speed_limit at 0x8.
module gravity_body_integrator import gbi_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   gbi_req_if.sink               req,
   gbi_rsp_if.source             rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [7:0]    body_mass_ff;
   logic [7:0]    gravity_gain_ff;
   logic [15:0]   speed_limit_ff;
   logic          csr_wr;
   cfg_type       cfg;
   logic          head_valid;
   logic          head_pop;
   req_item_type  head_item;
   fq_status_type fq_status;
   logic          rsp_valid;
   body_type      rsp_body;

   // register port: always ready, write lands on the access cycle
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         body_mass_ff    <= BODY_MASS_RESET;
         gravity_gain_ff <= GRAVITY_GAIN_RESET;
         speed_limit_ff  <= SPEED_LIMIT_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_BODY_MASS:    body_mass_ff    <= csr_pwdata[7:0];
            REG_GRAVITY_GAIN: gravity_gain_ff <= csr_pwdata[7:0];
            REG_SPEED_LIMIT:  speed_limit_ff  <= csr_pwdata[15:0];
            default: ;   // drop writes beyond the register list
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_BODY_MASS:    csr_prdata = {24'd0, body_mass_ff};
         REG_GRAVITY_GAIN: csr_prdata = {24'd0, gravity_gain_ff};
         REG_SPEED_LIMIT:  csr_prdata = {16'd0, speed_limit_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   assign cfg.body_mass    = body_mass_ff;
   assign cfg.gravity_gain = gravity_gain_ff;
   assign cfg.speed_limit  = speed_limit_ff;

   // front: take and classify items, hold them in a short queue
   gbi_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .head_item  (head_item),
      .status     (fq_status)
   );

   // back: run one item at a time and own the body state and result register
   gbi_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop),
      .rsp_ready  (rsp.ready),
      .rsp_valid  (rsp_valid),
      .rsp_body   (rsp_body)
   );

   assign rsp.valid   = rsp_valid;
   assign rsp.pos_x   = rsp_body.pos_x;
   assign rsp.pos_y   = rsp_body.pos_y;
   assign rsp.vel_x   = rsp_body.vel_x;
   assign rsp.vel_y   = rsp_body.vel_y;
   assign rsp.accel_x = rsp_body.accel_x;
   assign rsp.accel_y = rsp_body.accel_y;

   // no result comes out right after reset
   a_reset_quiet : assert property (@(posedge clock) reset |=> !rsp.valid)
      else $error("result valid right after reset");

   // queue flow control follows the fill level
   a_queue_ready : assert property (@(posedge clock) disable iff (reset)
      req.ready == (fq_status.count != 2'(QUEUE_DEPTH)))
      else $error("queue ready disagrees with fill level");

   a_mass_write : assert property (@(posedge clock) disable iff (reset)
      (csr_wr && csr_paddr[3:2] == REG_BODY_MASS) |=> body_mass_ff == $past(csr_pwdata[7:0]))
      else $error("body_mass write lost");

   a_limit_write : assert property (@(posedge clock) disable iff (reset)
      (csr_wr && csr_paddr[3:2] == REG_SPEED_LIMIT)
      |=> speed_limit_ff == $past(csr_pwdata[15:0]))
      else $error("speed_limit write lost");

endmodule

`default_nettype wire

// ===== sim/tb_gravity_body_integrator.sv =====
`timescale 1ns / 1ps

module tb_gravity_body_integrator;
   import gbi_pkg::*;

   localparam int FRAC = FRAC_BITS_DEFAULT;
   localparam int RANDOM_ITEMS = 1850;
   localparam int SETTLE_CYCLES = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #6 clock = ~clock;

   gbi_req_if req_ch ();
   gbi_rsp_if rsp_ch ();

   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [31:0]           csr_pwdata  = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   gravity_body_integrator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Body state and register copies that track the block.
   logic signed [31:0] body_px, body_py, body_vx, body_vy, body_ax, body_ay;
   logic [7:0]         mdl_mass, mdl_gain;
   logic [15:0]        mdl_limit;

   req_item_type pending_items[$];
   body_type     expected_bodies[$];
   req_item_type item_on_bus;
   bit           failed = 1'b0;

   function automatic logic [63:0] magnitude(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic [63:0] root64(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // min(floor(num * 2^e / den), cap)
   function automatic logic [63:0] scaled_quot(logic [63:0] num, int e, logic [63:0] den,
                                               logic [63:0] cap);
      logic [127:0] w;
      w = {64'd0, num} << e;
      w = w / {64'd0, den};
      return (w > {64'd0, cap}) ? cap : w[63:0];
   endfunction

   task automatic apply_pull(logic signed [31:0] ox, logic signed [31:0] oy, logic [7:0] om);
      longint      dx, dy, part;
      logic [63:0] ux, uy, vx, vy, q, rr, mag, cx, cy, rq, prod;
      logic [65:0] r2;
      int          s;
      dx = longint'(ox) - longint'(body_px);
      dy = longint'(oy) - longint'(body_py);
      ux = magnitude(dx);
      uy = magnitude(dy);
      r2 = 66'(ux) * 66'(ux) + 66'(uy) * 66'(uy);
      rq = 64'(mdl_mass) << (FRAC + 1);
      // inside the drawn radius: no pull at all
      if (66'(rq * rq) > r2) return;
      s = (((ux | uy) >> 31) != 0) ? 1 : 0;
      vx = ux >> s;
      vy = uy >> s;
      q = vx * vx + vy * vy;
      if (q == 0) return;
      rr = root64(q);
      mag = scaled_quot(64'(mdl_gain) * 64'(om), 3 * FRAC - 2 * s, q, 64'd1 << 32);
      cx = scaled_quot(vx, 31, rr, 64'd1 << 31);
      cy = scaled_quot(vy, 31, rr, 64'd1 << 31);
      prod = (mag * cx) >> 31;
      part = (dx < 0) ? -longint'(prod) : longint'(prod);
      body_ax = clamp32(longint'(body_ax) + part);
      prod = (mag * cy) >> 31;
      part = (dy < 0) ? -longint'(prod) : longint'(prod);
      body_ay = clamp32(longint'(body_ay) + part);
   endtask

   task automatic apply_advance();
      longint      nx, ny;
      logic [63:0] lq;
      logic [65:0] speed2;
      nx = longint'(body_vx) + longint'(body_ax);
      ny = longint'(body_vy) + longint'(body_ay);
      speed2 = 66'(magnitude(nx)) * 66'(magnitude(nx))
             + 66'(magnitude(ny)) * 66'(magnitude(ny));
      lq = 64'(mdl_limit) << FRAC;
      if (speed2 <= 66'(lq) * 66'(lq)) begin
         body_vx = clamp32(nx);
         body_vy = clamp32(ny);
      end
      body_px = body_px + body_vx;
      body_py = body_py + body_vy;
      body_ax = '0;
      body_ay = '0;
   endtask

   // Advance the tracked body by one item and queue the state it should report.
   task automatic predict_body(req_item_type it);
      body_type b;
      case (it.action)
         ACT_PLACE: begin
            body_px = it.other_x;
            body_py = it.other_y;
            body_vx = it.place_vel_x;
            body_vy = it.place_vel_y;
         end
         ACT_PULL:    apply_pull(it.other_x, it.other_y, it.other_mass);
         ACT_ADVANCE: apply_advance();
         default: ;
      endcase
      b.pos_x = body_px;
      b.pos_y = body_py;
      b.vel_x = body_vx;
      b.vel_y = body_vy;
      b.accel_x = body_ax;
      b.accel_y = body_ay;
      expected_bodies.push_back(b);
   endtask

   // Driver: bursts of items separated by random gaps.
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.action <= ACT_NOP;
         req_ch.other_x <= '0;
         req_ch.other_y <= '0;
         req_ch.other_mass <= '0;
         req_ch.place_vel_x <= '0;
         req_ch.place_vel_y <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) predict_body(item_on_bus);
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               item_on_bus = pending_items.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.action <= item_on_bus.action;
               req_ch.other_x <= item_on_bus.other_x;
               req_ch.other_y <= item_on_bus.other_y;
               req_ch.other_mass <= item_on_bus.other_mass;
               req_ch.place_vel_x <= item_on_bus.place_vel_x;
               req_ch.place_vel_y <= item_on_bus.place_vel_y;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  // end of burst: pick the next gap and burst length
                  burst_left = $urandom_range(0, 12);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: ready steps in turn through four patterns, from always high to rarely high.
   int unsigned cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         case ((cycle_count >> 8) % 4)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= $urandom_range(0, 1);
            2: rsp_ch.ready <= (cycle_count % 4 == 0);
            default: rsp_ch.ready <= ($urandom_range(0, 15) == 0);
         endcase
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_bodies.size() == 0) begin
               $error("result item with no expectation pending");
               failed = 1'b1;
            end else begin
               body_type e;
               e = expected_bodies.pop_front();
               if (rsp_ch.pos_x !== e.pos_x) begin
                  $error("pos_x: expected %0d, got %0d", e.pos_x, rsp_ch.pos_x);
                  failed = 1'b1;
               end
               if (rsp_ch.pos_y !== e.pos_y) begin
                  $error("pos_y: expected %0d, got %0d", e.pos_y, rsp_ch.pos_y);
                  failed = 1'b1;
               end
               if (rsp_ch.vel_x !== e.vel_x) begin
                  $error("vel_x: expected %0d, got %0d", e.vel_x, rsp_ch.vel_x);
                  failed = 1'b1;
               end
               if (rsp_ch.vel_y !== e.vel_y) begin
                  $error("vel_y: expected %0d, got %0d", e.vel_y, rsp_ch.vel_y);
                  failed = 1'b1;
               end
               if (rsp_ch.accel_x !== e.accel_x) begin
                  $error("accel_x: expected %0d, got %0d", e.accel_x, rsp_ch.accel_x);
                  failed = 1'b1;
               end
               if (rsp_ch.accel_y !== e.accel_y) begin
                  $error("accel_y: expected %0d, got %0d", e.accel_y, rsp_ch.accel_y);
                  failed = 1'b1;
               end
            end
         end
      end
   end

   task automatic queue_item(action_type act, logic signed [31:0] ox, logic signed [31:0] oy,
                             logic [7:0] om, logic signed [31:0] pvx,
                             logic signed [31:0] pvy);
      req_item_type it;
      it.action = act;
      it.other_x = ox;
      it.other_y = oy;
      it.other_mass = om;
      it.place_vel_x = pvx;
      it.place_vel_y = pvy;
      pending_items.push_back(it);
   endtask

   // Hold until every item went in and every result came back.
   task automatic wait_drained();
      @(negedge clock);
      while (pending_items.size() != 0 || expected_bodies.size() != 0 || req_ch.valid)
         @(negedge clock);
   endtask

   // Setup cycle, then access cycle; mirror the register at the access edge.
   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'(idx) << 2;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_BODY_MASS:    mdl_mass = value[7:0];
         REG_GRAVITY_GAIN: mdl_gain = value[7:0];
         REG_SPEED_LIMIT:  mdl_limit = value[15:0];
         default: ;
      endcase
   endtask

   function automatic logic signed [31:0] rand_coord();
      logic signed [31:0] v;
      v = $urandom >> $urandom_range(0, 31);
      return ($urandom_range(0, 1) == 1) ? -v : v;
   endfunction

   function automatic logic signed [31:0] rand_offset();
      logic signed [31:0] v;
      v = $urandom >> $urandom_range(6, 30);
      return ($urandom_range(0, 1) == 1) ? -v : v;
   endfunction

   // Mostly well-formed frames: place, several pulls, advance, a few more
   // pulls and advances; the rest is noise.
   task automatic queue_random(int count);
      int n;
      logic signed [31:0] px, py;
      n = 0;
      while (n < count) begin
         if ($urandom_range(0, 9) < 8) begin
            px = ($urandom_range(0, 4) == 0) ? $urandom : rand_coord();
            py = ($urandom_range(0, 4) == 0) ? $urandom : rand_coord();
            queue_item(ACT_PLACE, px, py, $urandom, rand_coord() >>> $urandom_range(0, 8),
                       rand_coord() >>> $urandom_range(0, 8));
            n++;
            repeat ($urandom_range(1, 3)) begin
               repeat ($urandom_range(1, 4)) begin
                  queue_item(ACT_PULL, px + rand_offset(), py + rand_offset(),
                             $urandom, $urandom, $urandom);
                  n++;
               end
               queue_item(ACT_ADVANCE, $urandom, $urandom, $urandom, $urandom, $urandom);
               n++;
            end
         end else begin
            queue_item(action_type'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                       $urandom, $urandom);
            n++;
         end
      end
   endtask

   initial begin
      body_px = '0; body_py = '0; body_vx = '0; body_vy = '0; body_ax = '0; body_ay = '0;
      mdl_mass = BODY_MASS_RESET;
      mdl_gain = GRAVITY_GAIN_RESET;
      mdl_limit = SPEED_LIMIT_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset registers: extremes, every action, radius edge.
      queue_item(ACT_NOP, '1, '1, '1, '1, '1);
      queue_item(ACT_PLACE, 32'sh7fffffff, 32'sh80000000, 8'hff, 32'sh7fffffff, 32'sh80000000);
      queue_item(ACT_ADVANCE, '0, '0, '0, '0, '0);
      queue_item(ACT_PULL, 32'sh80000000, 32'sh7fffffff, 8'hff, '0, '0);
      queue_item(ACT_PULL, '0, '0, 8'd0, '0, '0);
      queue_item(ACT_PLACE, '0, '0, '0, 32'sh00010000, -32'sh00020000);
      queue_item(ACT_PULL, 32'sh00040000, '0, 8'd10, '0, '0);   // exactly on the radius
      queue_item(ACT_PULL, 32'sh0003ffff, '0, 8'd10, '0, '0);   // just inside
      queue_item(ACT_PULL, -32'sh00100000, 32'sh00100000, 8'd200, '0, '0);
      queue_item(ACT_ADVANCE, '0, '0, '0, '0, '0);
      queue_item(ACT_PLACE, '0, '0, '0, 32'sh03e80000, '0);     // at the speed limit
      queue_item(ACT_PULL, 32'sh00050000, '0, 8'hff, '0, '0);
      queue_item(ACT_ADVANCE, '0, '0, '0, '0, '0);               // over it: kept
      queue_item(ACT_PULL, 32'sh7fffffff, 32'sh7fffffff, 8'hff, '0, '0);
      queue_item(ACT_NOP, '0, '0, '0, '0, '0);
      queue_item(ACT_ADVANCE, '0, '0, '0, '0, '0);
      wait_drained();

      // Coincident bodies need a zero mass; also hit an unmapped address.
      write_reg(REG_BODY_MASS, 32'd0);
      write_reg(2'd3, 32'hffffffff);
      queue_item(ACT_PLACE, 32'sh12345678, -32'sh00abcdef, '0, '0, '0);
      queue_item(ACT_PULL, 32'sh12345678, -32'sh00abcdef, 8'hff, '0, '0);
      queue_item(ACT_PULL, 32'sh12345679, -32'sh00abcdef, 8'hff, '0, '0);
      queue_item(ACT_ADVANCE, '0, '0, '0, '0, '0);
      wait_drained();

      // Random phases across register settings, extremes included.
      write_reg(REG_BODY_MASS, 32'd1);
      write_reg(REG_GRAVITY_GAIN, 32'd255);
      write_reg(REG_SPEED_LIMIT, 32'd65535);
      queue_random(RANDOM_ITEMS / 6);
      wait_drained();

      write_reg(REG_BODY_MASS, 32'd255);
      write_reg(REG_GRAVITY_GAIN, 32'd0);
      write_reg(REG_SPEED_LIMIT, 32'd0);
      queue_random(RANDOM_ITEMS / 6);
      wait_drained();

      write_reg(REG_BODY_MASS, 32'd2);
      write_reg(REG_GRAVITY_GAIN, 32'd2);
      write_reg(REG_SPEED_LIMIT, 32'd1000);
      queue_random(RANDOM_ITEMS / 6);
      wait_drained();

      repeat (3) begin
         write_reg(REG_BODY_MASS, $urandom_range(1, 255) | 32'hffffff00);
         write_reg(REG_GRAVITY_GAIN, $urandom);
         write_reg(REG_SPEED_LIMIT, $urandom);
         queue_random(RANDOM_ITEMS / 6);
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (!failed && expected_bodies.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         if (expected_bodies.size() != 0) $error("%0d results never arrived",
                                                 expected_bodies.size());
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/gbi_pkg.sv
hdl/gbi_req_if.sv
hdl/gbi_rsp_if.sv
hdl/gbi_front.sv
hdl/gbi_div.sv
hdl/gbi_back.sv
hdl/gravity_body_integrator.sv
sim/tb_gravity_body_integrator.sv
